// ===== hw/rtl/hcc_pkg.sv =====
// Package: widths, command codes, pipeline word and the per-level Hilbert step.
`default_nettype none

package hcc_pkg;

    localparam int COORD_BITS = 8;
    localparam int IDX_W      = 2 * COORD_BITS;
    localparam int LVL_W      = (COORD_BITS > 1) ? $clog2(COORD_BITS) : 1;

    typedef logic [COORD_BITS-1:0] crd_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [LVL_W-1:0]      lvl_t;

    typedef enum logic {
        CMD_IDX_TO_XY = 1'b0,
        CMD_XY_TO_IDX = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        idx_t d;
        crd_t x;
        crd_t y;
    } hcc_word_t;

    // One curve level. Index to cell: cell at position k handles level k.
    // Cell to index: cell at position k handles level COORD_BITS-1-k.
    function automatic hcc_word_t hcc_cell_step(hcc_word_t w, lvl_t pos);
        hcc_word_t r;
        crd_t      bit_s;
        crd_t      lo;
        crd_t      x;
        crd_t      y;
        crd_t      t;
        logic      rx;
        logic      ry;
        int        lvl;
        r = w;
        if (w.cmd == CMD_IDX_TO_XY)
        begin
            lvl = int'(pos);
        end
        else
        begin
            lvl = COORD_BITS - 1 - int'(pos);
        end
        bit_s = crd_t'(1) << lvl;
        lo    = bit_s - crd_t'(1);
        x     = w.x & lo;
        y     = w.y & lo;
        if (w.cmd == CMD_IDX_TO_XY)
        begin
            rx = w.d[2*lvl+1];
            ry = w.d[2*lvl] ^ rx;
        end
        else
        begin
            rx = w.x[lvl];
            ry = w.y[lvl];
            r.d[2*lvl+1] = rx;
            r.d[2*lvl]   = rx ^ ry;
        end
        if (!ry)
        begin
            if (rx)
            begin
                x = ~x & lo;
                y = ~y & lo;
            end
            t = x;
            x = y;
            y = t;
        end
        if (w.cmd == CMD_IDX_TO_XY)
        begin
            x = x | (rx ? bit_s : '0);
            y = y | (ry ? bit_s : '0);
        end
        r.x = x;
        r.y = y;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hcc_if.sv =====
// Request and response channel interfaces with valid/ready handshake.
`default_nettype none

interface hcc_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] curve_index;
    logic [7:0]  coord_x;
    logic [7:0]  coord_y;

    modport source (output valid, output command, output curve_index,
                    output coord_x, output coord_y, input ready);
    modport sink   (input valid, input command, input curve_index,
                    input coord_x, input coord_y, output ready);
endinterface

interface hcc_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_index;
    logic [7:0]  result_x;
    logic [7:0]  result_y;

    modport source (output valid, output result_index, output result_x,
                    output result_y, input ready);
    modport sink   (input valid, input result_index, input result_x,
                    input result_y, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hcc_cell.sv =====
// One level cell of the conversion chain: step logic plus a registered stage.
`default_nettype none

module hcc_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hcc_pkg::lvl_t     pos,
    input  wire logic              up_valid,
    output logic                   up_ready,
    input  wire hcc_pkg::hcc_word_t up_data,
    output logic                   dn_valid,
    input  wire logic              dn_ready,
    output hcc_pkg::hcc_word_t     dn_data
);
    import hcc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    hcc_word_t data_reg;

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= hcc_cell_step(up_data, pos);
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hilbert_curve_index_convert_core.sv =====
// Top level: Hilbert curve index <-> (x, y) converter built as a chain of level cells.
// Each request transaction passes a row of COORD_BITS (8) registered cells, one
// per curve level, on its way to the response side. A new request is taken every
// cycle while the response side is ready; each cell has its own valid bit and a
// cell moves on as soon as the next one is free, so a stalled response only stops
// the cells that are full behind it. The chain length, one cell per level, sets
// the latency. command 0 maps curve_index to (result_x, result_y) with
// result_index zero; command 1 maps (coord_x, coord_y) to result_index with
// result_x and result_y zero. No state is kept between transactions.
`default_nettype none

module hilbert_curve_index_convert_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hcc_req_if.sink    req,
    hcc_rsp_if.source  rsp
);
    import hcc_pkg::*;

    logic      chain_valid [0:COORD_BITS];
    logic      chain_ready [0:COORD_BITS];
    hcc_word_t chain_data  [0:COORD_BITS];
    hcc_word_t tail;

    assign chain_valid[0]    = req.valid;
    assign req.ready         = chain_ready[0];
    assign chain_data[0].cmd = cmd_t'(req.command);
    assign chain_data[0].d   = (req.command == CMD_IDX_TO_XY) ? req.curve_index : '0;
    assign chain_data[0].x   = (req.command == CMD_XY_TO_IDX) ? req.coord_x : '0;
    assign chain_data[0].y   = (req.command == CMD_XY_TO_IDX) ? req.coord_y : '0;

    for (genvar k = 0; k < COORD_BITS; k++)
    begin : g_cell
        hcc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .pos      (lvl_t'(k)),
            .up_valid (chain_valid[k]),
            .up_ready (chain_ready[k]),
            .up_data  (chain_data[k]),
            .dn_valid (chain_valid[k+1]),
            .dn_ready (chain_ready[k+1]),
            .dn_data  (chain_data[k+1])
        );
    end

    assign tail                   = chain_data[COORD_BITS];
    assign rsp.valid              = chain_valid[COORD_BITS];
    assign chain_ready[COORD_BITS] = rsp.ready;
    assign rsp.result_index       = (tail.cmd == CMD_XY_TO_IDX) ? tail.d : '0;
    assign rsp.result_x           = (tail.cmd == CMD_IDX_TO_XY) ? tail.x : '0;
    assign rsp.result_y           = (tail.cmd == CMD_IDX_TO_XY) ? tail.y : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/hcc_checker.sv =====
// Port-level assertions for the converter core and their bind.
`default_nettype none

module hcc_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    input  wire logic        req_ready,
    input  wire logic        rsp_valid,
    input  wire logic        rsp_ready,
    input  wire logic [15:0] rsp_result_index,
    input  wire logic [7:0]  rsp_result_x,
    input  wire logic [7:0]  rsp_result_y
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_result_index == 16'd0) ||
                      (rsp_result_x == 8'd0 && rsp_result_y == 8'd0))
        else $error("response carries both index and coordinates");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request blocked with empty response side");

    a_stall_moves: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("transaction accepted under stall lost pending response");

endmodule

bind hilbert_curve_index_convert_core hcc_checker u_hcc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_result_index (rsp.result_index),
    .rsp_result_x     (rsp.result_x),
    .rsp_result_y     (rsp.result_y)
);

`default_nettype wire
